// File: rtl/pixel_to_mono_bayer_dither_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel to mono Bayer dither unit
// Each macro expands to one labeled concurrent assertion clocked on clock
// and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_MONO_BAYER_DITHER_UNIT_DEFINES_SVH
`define PIXEL_TO_MONO_BAYER_DITHER_UNIT_DEFINES_SVH

// same-cycle implication
`define PMBD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PMBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pmbd_pkg.sv
// ----------------------------------------------------------------------------
// pmbd_pkg
// Pixel format codes, output levels and constant tables for the dither unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmbd_pkg;

   typedef logic [1:0] fmt_type;

   localparam fmt_type FMT_RGB565   = 2'd0;
   localparam fmt_type FMT_RGB888   = 2'd1;
   localparam fmt_type FMT_RGBA8888 = 2'd2;
   localparam fmt_type FMT_GRAY8    = 2'd3;

   localparam logic [7:0] MONO_BLACK = 8'h00;
   localparam logic [7:0] MONO_WHITE = 8'hFF;

   // luma weights, sum is 100x gray
   localparam int LUMA_W = 15;
   localparam logic [LUMA_W-1:0] WEIGHT_R = 15'd30;
   localparam logic [LUMA_W-1:0] WEIGHT_G = 15'd59;
   localparam logic [LUMA_W-1:0] WEIGHT_B = 15'd11;
   localparam logic [LUMA_W-1:0] LUMA_DIV = 15'd100;

   // darkness > t  <=>  gray < 240 - 16*t
   localparam logic [7:0] LEVEL_TOP = 8'd240;

   typedef logic [3:0] bayer_lut_type [16];

   // indexed by {y[1:0], x[1:0]}
   localparam bayer_lut_type BAYER_THR = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   typedef logic [7:0] exp5_lut_type [32];
   typedef logic [7:0] exp6_lut_type [64];

   function automatic exp5_lut_type build_exp5_lut();
      exp5_lut_type lut;
      for (int i = 0; i < 32; i++) begin
         lut[i] = 8'((i * 255) / 31);
      end
      return lut;
   endfunction

   function automatic exp6_lut_type build_exp6_lut();
      exp6_lut_type lut;
      for (int i = 0; i < 64; i++) begin
         lut[i] = 8'((i * 255) / 63);
      end
      return lut;
   endfunction

   localparam exp5_lut_type EXP5_LUT = build_exp5_lut();
   localparam exp6_lut_type EXP6_LUT = build_exp6_lut();

endpackage

`default_nettype wire

// File: rtl/pixel_to_mono_bayer_dither_unit.sv
// ----------------------------------------------------------------------------
// pixel_to_mono_bayer_dither_unit
// Converts one pixel to black or white with a 4x4 Bayer ordered dither.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per pixel, pixel word plus destination x and y.
//            Only the low two bits of x and y select the dither cell.
//   rsp_*  : one result per request, rsp_mono_level is 0 or 255, in order.
//   csr_*  : writes the 2-bit pixel format (565, 888, 8888 with alpha, gray8).
//            Always ready; write only while no request is in flight.
// Timing:
//   Two register stages, an input register and a result register, with the
//   conversion logic between them. A taken request passes through the input
//   register and then the result register, which drives rsp_*.
//   One request per cycle unless rsp_ready holds the result and stalls input.
// Stall:
//   When rsp_ready is low the result holds, the input register still fills,
//   and req_ready drops only once both stages hold requests.
// Reset:
//   Synchronous, active high: both stages empty, pixel format back to rgb565.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_to_mono_bayer_dither_unit_defines.svh"

module pixel_to_mono_bayer_dither_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   // config
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire pmbd_pkg::fmt_type csr_pixel_format,
   // request
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [31:0]       req_pixel_word,
   input  wire logic [15:0]       req_dest_x,
   input  wire logic [15:0]       req_dest_y,
   // response
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_mono_level
);
   import pmbd_pkg::*;

   fmt_type     fmt_ff, fmt_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff, s1_word_in;
   logic [1:0]  s1_x_ff, s1_x_in;
   logic [1:0]  s1_y_ff, s1_y_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_mono_ff, rsp_mono_in;

   logic        s1_advance;
   logic        req_take;
   logic [7:0]  shade_mono;

   assign csr_ready = 1'b1;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   pmbd_shade u_shade (
      .pixel_format (fmt_ff),
      .pixel_word   (s1_word_ff),
      .dest_x       (s1_x_ff),
      .dest_y       (s1_y_ff),
      .mono_level   (shade_mono)
   );

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_valid && csr_ready) begin
         fmt_in = csr_pixel_format;
      end

      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (req_take) begin
         s1_word_in = req_pixel_word;
         s1_x_in    = req_dest_x[1:0];
         s1_y_in    = req_dest_y[1:0];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_mono_in  = rsp_mono_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_mono_in  = shade_mono;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_RGB565;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      rsp_mono_ff <= rsp_mono_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mono_level = rsp_mono_ff;

   `PMBD_ASSERT_NOW(a_mono_two_level, rsp_valid_ff, (rsp_mono_ff == MONO_BLACK) || (rsp_mono_ff == MONO_WHITE), "result level is neither black nor white")
   `PMBD_ASSERT_NOW(a_stall_only_full, !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready, "request blocked while a stage is free")
   `PMBD_ASSERT_NEXT(a_take_fills_s1, req_take, s1_valid_ff, "accepted request lost from input stage")
   `PMBD_ASSERT_NEXT(a_s1_moves_out, s1_valid_ff && s1_advance, rsp_valid_ff, "input stage advanced without a result")
   `PMBD_ASSERT_NEXT(a_fmt_written, csr_valid && csr_ready, fmt_ff == $past(csr_pixel_format), "pixel format write not stored")

endmodule

`default_nettype wire

// File: rtl/pmbd_shade.sv
// ----------------------------------------------------------------------------
// pmbd_shade
// Combinational pixel to mono conversion: format decode, luma, dither compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmbd_shade (
   input  wire pmbd_pkg::fmt_type pixel_format,
   input  wire logic [31:0]       pixel_word,
   input  wire logic [1:0]        dest_x,
   input  wire logic [1:0]        dest_y,
   output logic [7:0]             mono_level
);
   import pmbd_pkg::*;

   logic [7:0]        red;
   logic [7:0]        green;
   logic [7:0]        blue;
   logic [LUMA_W-1:0] luma_sum;
   logic [3:0]        thr;
   logic [7:0]        level;
   logic [LUMA_W-1:0] luma_limit;
   logic              transparent;
   logic              dark;

   always_comb begin
      case (pixel_format)
         FMT_RGB565: begin
            red   = EXP5_LUT[pixel_word[15:11]];
            green = EXP6_LUT[pixel_word[10:5]];
            blue  = EXP5_LUT[pixel_word[4:0]];
         end
         default: begin
            red   = pixel_word[7:0];
            green = pixel_word[15:8];
            blue  = pixel_word[23:16];
         end
      endcase
   end

   assign luma_sum = LUMA_W'(red)   * WEIGHT_R
                   + LUMA_W'(green) * WEIGHT_G
                   + LUMA_W'(blue)  * WEIGHT_B;

   assign thr        = BAYER_THR[{dest_y, dest_x}];
   assign level      = LEVEL_TOP - {thr, 4'b0000};
   assign luma_limit = LUMA_W'(level) * LUMA_DIV;

   // alpha below 128 forces white
   assign transparent = (pixel_format == FMT_RGBA8888) && !pixel_word[31];

   always_comb begin
      case (pixel_format)
         FMT_GRAY8:                dark = pixel_word[7:0] < level;
         FMT_RGB565, FMT_RGB888:   dark = luma_sum < luma_limit;
         FMT_RGBA8888:             dark = !transparent && (luma_sum < luma_limit);
         default:                  dark = 1'b0;
      endcase
   end

   assign mono_level = dark ? MONO_BLACK : MONO_WHITE;

endmodule

`default_nettype wire
